FILE: rtl/websocket_frame_decoder_assert.svh
// Assertion macros used by the frame decoder top level.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame decoder same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WSFD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame decoder next-cycle check failed");

`endif

FILE: rtl/wsfd_pkg.sv
// Types and constants of the WebSocket frame decoder.
package wsfd_pkg;

  localparam int RESULT_DEPTH = 4;

  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_COMPLETE  = 2'd1;
  localparam logic [1:0] KIND_TRUNCATED = 2'd2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    PH_BYTE1   = 3'd0,
    PH_BYTE2   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] frame_len;
    logic        last;
  } out_t;

  typedef struct packed {
    logic v0;
    logic v1;
    out_t r0;
    out_t r1;
  } gen_t;

endpackage

FILE: rtl/wsfd_parser.sv
// Frame header state machine, payload unmasking and result generation.
module wsfd_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  wsfd_pkg::in_t  item,
  output wsfd_pkg::gen_t gen
);

  wsfd_pkg::phase_t phase, phase_adv, phase_next;
  logic [7:0]  header_bits, header_adv, header_next;
  logic        mask_flag, mask_adv, mask_next;
  logic [63:0] length_value, length_adv, length_next;
  logic [3:0]  bytes_left, bytes_left_adv, bytes_left_next, bytes_left_dec;
  logic [31:0] mask_key, mask_key_adv, mask_key_next;
  logic [63:0] payload_index, index_adv, index_next, index_inc;
  logic [6:0]  len7;

  logic        pay, complete, trunc;
  logic [7:0]  key_byte, pay_data;
  wsfd_pkg::out_t hdr_res, pay_res, comp_res, trunc_res;

  assign len7           = item.data_byte[6:0];
  assign bytes_left_dec = bytes_left - 4'd1;
  assign index_inc      = payload_index + 64'd1;

  always_comb begin
    phase_adv      = phase;
    header_adv     = header_bits;
    mask_adv       = mask_flag;
    length_adv     = length_value;
    bytes_left_adv = bytes_left;
    mask_key_adv   = mask_key;
    index_adv      = payload_index;
    unique case (phase)
      wsfd_pkg::PH_BYTE1: begin
        header_adv = item.data_byte;
        phase_adv  = wsfd_pkg::PH_BYTE2;
      end
      wsfd_pkg::PH_BYTE2: begin
        mask_adv = item.data_byte[7];
        if (len7 == wsfd_pkg::LEN_EXT16) begin
          length_adv     = '0;
          bytes_left_adv = 4'd2;
          phase_adv      = wsfd_pkg::PH_EXTLEN;
        end else if (len7 == wsfd_pkg::LEN_EXT64) begin
          length_adv     = '0;
          bytes_left_adv = 4'd8;
          phase_adv      = wsfd_pkg::PH_EXTLEN;
        end else begin
          length_adv = {57'd0, len7};
          if (item.data_byte[7]) begin
            bytes_left_adv = 4'd4;
            mask_key_adv   = '0;
            phase_adv      = wsfd_pkg::PH_KEY;
          end else begin
            index_adv = '0;
            phase_adv = (len7 == 7'd0) ? wsfd_pkg::PH_TRAILER : wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        length_adv     = {length_value[55:0], item.data_byte};
        bytes_left_adv = bytes_left_dec;
        if (bytes_left_dec == 4'd0) begin
          if (mask_flag) begin
            bytes_left_adv = 4'd4;
            mask_key_adv   = '0;
            phase_adv      = wsfd_pkg::PH_KEY;
          end else begin
            index_adv = '0;
            phase_adv = ({length_value[55:0], item.data_byte} == 64'd0) ?
                        wsfd_pkg::PH_TRAILER : wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_KEY: begin
        mask_key_adv   = {mask_key[23:0], item.data_byte};
        bytes_left_adv = bytes_left_dec;
        if (bytes_left_dec == 4'd0) begin
          index_adv = '0;
          phase_adv = (length_value == 64'd0) ? wsfd_pkg::PH_TRAILER : wsfd_pkg::PH_PAYLOAD;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        index_adv = index_inc;
        if (index_inc == length_value) begin
          phase_adv = wsfd_pkg::PH_TRAILER;
        end
      end
      wsfd_pkg::PH_TRAILER: begin
        phase_adv = wsfd_pkg::PH_TRAILER;
      end
      default: begin
        phase_adv = phase;
      end
    endcase
  end

  always_comb begin
    if (item.end_of_buffer) begin
      phase_next      = wsfd_pkg::PH_BYTE1;
      header_next     = '0;
      mask_next       = 1'b0;
      length_next     = '0;
      bytes_left_next = '0;
      mask_key_next   = '0;
      index_next      = '0;
    end else begin
      phase_next      = phase_adv;
      header_next     = header_adv;
      mask_next       = mask_adv;
      length_next     = length_adv;
      bytes_left_next = bytes_left_adv;
      mask_key_next   = mask_key_adv;
      index_next      = index_adv;
    end
  end

  always_comb begin
    case (payload_index[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    pay_data = mask_flag ? (item.data_byte ^ key_byte) : item.data_byte;

    pay      = (phase == wsfd_pkg::PH_PAYLOAD);
    complete = (phase_adv == wsfd_pkg::PH_TRAILER) && (phase != wsfd_pkg::PH_TRAILER);
    trunc    = item.end_of_buffer && (phase_adv != wsfd_pkg::PH_TRAILER);

    hdr_res.kind      = wsfd_pkg::KIND_PAYLOAD;
    hdr_res.data      = '0;
    hdr_res.fin       = header_adv[7];
    hdr_res.rsv       = header_adv[6:4];
    hdr_res.opcode    = header_adv[3:0];
    hdr_res.masked    = mask_adv;
    hdr_res.frame_len = length_adv;
    hdr_res.last      = 1'b0;

    pay_res      = hdr_res;
    pay_res.data = pay_data;

    comp_res      = hdr_res;
    comp_res.kind = wsfd_pkg::KIND_COMPLETE;
    comp_res.last = 1'b1;

    trunc_res      = '0;
    trunc_res.kind = wsfd_pkg::KIND_TRUNCATED;
    trunc_res.last = 1'b1;

    gen.v0 = pay || complete || trunc;
    gen.v1 = pay && (complete || trunc);
    gen.r0 = pay ? pay_res : (complete ? comp_res : trunc_res);
    gen.r1 = complete ? comp_res : trunc_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wsfd_pkg::PH_BYTE1;
      header_bits   <= '0;
      mask_flag     <= 1'b0;
      length_value  <= '0;
      bytes_left    <= '0;
      mask_key      <= '0;
      payload_index <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      header_bits   <= header_next;
      mask_flag     <= mask_next;
      length_value  <= length_next;
      bytes_left    <= bytes_left_next;
      mask_key      <= mask_key_next;
      payload_index <= index_next;
    end
  end

endmodule

FILE: rtl/wsfd_result_fifo.sv
// Result queue that takes up to two result items per cycle and hands out one.
module wsfd_result_fifo #(
  parameter int DEPTH = wsfd_pkg::RESULT_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  wsfd_pkg::gen_t gen,
  input  logic           pop,
  output logic           room,
  output logic           not_empty,
  output wsfd_pkg::out_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsfd_pkg::out_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr1, wr_ptr2, rd_ptr, rd_ptr1, wr_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          push0, push1;

  assign push0 = accept && gen.v0;
  assign push1 = accept && gen.v1;

  assign wr_ptr1 = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
  assign wr_ptr2 = (wr_ptr1 == PW'(DEPTH - 1)) ? '0 : wr_ptr1 + PW'(1);
  assign rd_ptr1 = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);

  assign wr_ptr_next = push1 ? wr_ptr2 : (push0 ? wr_ptr1 : wr_ptr);
  assign count_next  = count + CW'(push0) + CW'(push1) - CW'(pop);

  assign room      = (count <= CW'(DEPTH - 2));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= gen.r0;
    end
    if (push1) begin
      mem[wr_ptr1] <= gen.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr1;
      end
    end
  end

endmodule

FILE: rtl/websocket_frame_decoder.sv
// WebSocket frame decoder top level: byte parser feeding a result queue.
// The decoder takes one byte per clock while in_ready is high and parses one RFC 6455
// frame from the start of each buffer, giving one payload byte result per payload byte,
// a completion result after the last payload byte and a truncation result when the
// buffer ends early. A byte is taken in the cycle it arrives whenever the result queue
// (FIFO_DEPTH entries, at least two) has two free entries; its results are registered
// into the queue. The output side moves one result per cycle while out_ready is high, so
// a byte that gives two results (the last payload byte with its completion, or a payload
// byte that ends the buffer early) is queued; the input stalls without two free entries.
module websocket_frame_decoder #(
  parameter int FIFO_DEPTH = wsfd_pkg::RESULT_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wsfd_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output wsfd_pkg::out_t out_item
);

  `include "websocket_frame_decoder_assert.svh"

  logic           in_fire;
  logic           out_fire;
  wsfd_pkg::gen_t gen;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  wsfd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (in_fire),
    .item   (in_item),
    .gen    (gen)
  );

  wsfd_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_fire),
    .gen       (gen),
    .pop       (out_fire),
    .room      (in_ready),
    .not_empty (out_valid),
    .head      (out_item)
  );

  `WSFD_ASSERT_IMP(a_second_after_first, in_fire && gen.v1, gen.v0 && gen.r1.last)
  `WSFD_ASSERT_NXT(a_result_shows, in_fire && gen.v0, out_valid)
  `WSFD_ASSERT_IMP(a_payload_not_last,
                   out_valid && (out_item.kind == wsfd_pkg::KIND_PAYLOAD),
                   !out_item.last)
  `WSFD_ASSERT_IMP(a_trunc_no_header,
                   out_valid && (out_item.kind == wsfd_pkg::KIND_TRUNCATED),
                   out_item.last && (out_item.frame_len == 64'd0))

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the WebSocket frame decoder with a queue-fed driver and monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASE_ITEMS = 120;
  localparam int PAYLOAD_CAP = 130;

  typedef struct {
    wsfd_pkg::in_t item;
    int            send_idle;
    int            recv_idle;
    bit            hold;
  } pending_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  wsfd_pkg::in_t  in_item = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  wsfd_pkg::out_t out_item;

  pending_t       pending[$];
  wsfd_pkg::out_t frame_results[$];
  logic           in_taken = 1'b0;
  int             recv_stall = 0;
  int             errors = 0;
  int             quiet = 0;

  // Decoder state mirrored by the predictor.
  wsfd_pkg::phase_t ph = wsfd_pkg::PH_BYTE1;
  logic [7:0]  hdr = '0;
  logic        mflag = 1'b0;
  logic [63:0] plen_acc = '0;
  logic [3:0]  field_left = '0;
  logic [31:0] key = '0;
  logic [63:0] pay_idx = '0;

  logic [8:0] directed [24] = '{
    9'h081, 9'h000, 9'h155,
    9'h100,
    9'h07A, 9'h0FF, 9'h080, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h005,
    9'h001, 9'h002, 9'h003, 9'h004, 9'h1AA,
    9'h0FF, 9'h07E, 9'h000, 9'h001, 9'h1FF
  };

  int sidle_of [4] = '{0, 64, 0, 32};
  int ridle_of [4] = '{0, 0, 64, 32};

  websocket_frame_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void push_result(logic [1:0] kind, logic [7:0] data, bit with_hdr,
                                      logic last);
    wsfd_pkg::out_t r;
    r = '0;
    r.kind = kind;
    r.data = data;
    if (with_hdr) begin
      r.fin = hdr[7];
      r.rsv = hdr[6:4];
      r.opcode = hdr[3:0];
      r.masked = mflag;
      r.frame_len = plen_acc;
    end
    r.last = last;
    frame_results.push_back(r);
  endfunction

  function automatic void finish_header();
    pay_idx = '0;
    if (plen_acc == 64'd0) begin
      push_result(wsfd_pkg::KIND_COMPLETE, 8'd0, 1'b1, 1'b1);
      ph = wsfd_pkg::PH_TRAILER;
    end else begin
      ph = wsfd_pkg::PH_PAYLOAD;
    end
  endfunction

  function automatic void finish_length();
    if (mflag) begin
      field_left = 4'd4;
      key = '0;
      ph = wsfd_pkg::PH_KEY;
    end else begin
      finish_header();
    end
  endfunction

  function automatic void decode_byte(wsfd_pkg::in_t it);
    logic [7:0] b;
    logic [7:0] v;
    b = it.data_byte;
    case (ph)
      wsfd_pkg::PH_BYTE1: begin
        hdr = b;
        ph = wsfd_pkg::PH_BYTE2;
      end
      wsfd_pkg::PH_BYTE2: begin
        mflag = b[7];
        plen_acc = '0;
        if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
          field_left = 4'd2;
          ph = wsfd_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
          field_left = 4'd8;
          ph = wsfd_pkg::PH_EXTLEN;
        end else begin
          plen_acc = {57'd0, b[6:0]};
          finish_length();
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        plen_acc = {plen_acc[55:0], b};
        field_left = field_left - 4'd1;
        if (field_left == 4'd0) finish_length();
      end
      wsfd_pkg::PH_KEY: begin
        key = {key[23:0], b};
        field_left = field_left - 4'd1;
        if (field_left == 4'd0) finish_header();
      end
      wsfd_pkg::PH_PAYLOAD: begin
        v = b;
        if (mflag) v = v ^ key[8 * (3 - pay_idx[1:0]) +: 8];
        push_result(wsfd_pkg::KIND_PAYLOAD, v, 1'b1, 1'b0);
        pay_idx = pay_idx + 64'd1;
        if (pay_idx == plen_acc) begin
          push_result(wsfd_pkg::KIND_COMPLETE, 8'd0, 1'b1, 1'b1);
          ph = wsfd_pkg::PH_TRAILER;
        end
      end
      default: begin
      end
    endcase
    if (it.end_of_buffer) begin
      if (ph != wsfd_pkg::PH_TRAILER) push_result(wsfd_pkg::KIND_TRUNCATED, 8'd0, 1'b0, 1'b1);
      ph = wsfd_pkg::PH_BYTE1;
      hdr = '0;
      mflag = 1'b0;
      plen_acc = '0;
      field_left = '0;
      key = '0;
      pay_idx = '0;
    end
  endfunction

  function automatic void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void check_result(wsfd_pkg::out_t e, wsfd_pkg::out_t a);
    cmp_field("kind", 64'(e.kind), 64'(a.kind));
    cmp_field("data", 64'(e.data), 64'(a.data));
    cmp_field("fin", 64'(e.fin), 64'(a.fin));
    cmp_field("rsv", 64'(e.rsv), 64'(a.rsv));
    cmp_field("opcode", 64'(e.opcode), 64'(a.opcode));
    cmp_field("masked", 64'(e.masked), 64'(a.masked));
    cmp_field("frame_len", e.frame_len, a.frame_len);
    cmp_field("last", 64'(e.last), 64'(a.last));
  endfunction

  function automatic void add_byte(logic [7:0] b, logic eob, int sidle, int ridle, bit hold);
    pending_t p;
    p.item.data_byte = b;
    p.item.end_of_buffer = eob;
    p.send_idle = sidle;
    p.recv_idle = ridle;
    p.hold = hold;
    pending.push_back(p);
  endfunction

  // One buffer: a frame with random content, mostly well formed, sometimes cut short.
  function automatic void add_buffer(int sidle, int ridle, bit hold);
    logic [7:0]  bytes[$];
    logic [63:0] plen;
    logic        msk;
    bit          broken;
    int          sel;
    int          npay;
    int          cut;
    int          ntrail;
    bytes.push_back(8'($urandom));
    msk = 1'($urandom_range(1));
    sel = $urandom_range(99);
    if (sel < 10) begin
      plen = 64'($urandom_range(1, 6));
      for (int i = 1; i < int'(plen); i++) bytes.push_back(8'($urandom));
    end else if (sel < 60) begin
      plen = (sel < 14) ? 64'd125 : 64'($urandom_range(0, 12));
      bytes.push_back({msk, plen[6:0]});
    end else if (sel < 82) begin
      plen = (sel < 77) ? 64'($urandom_range(0, 12)) : 64'($urandom_range(0, 16'hFFFF));
      bytes.push_back({msk, wsfd_pkg::LEN_EXT16});
      bytes.push_back(plen[15:8]);
      bytes.push_back(plen[7:0]);
    end else begin
      plen = (sel < 95) ? 64'($urandom_range(0, 12)) : {$urandom, $urandom};
      bytes.push_back({msk, wsfd_pkg::LEN_EXT64});
      for (int i = 7; i >= 0; i--) bytes.push_back(plen[8 * i +: 8]);
    end
    if (sel >= 10) begin
      if (msk) begin
        for (int i = 0; i < 4; i++) bytes.push_back(8'($urandom));
      end
      broken = (plen > 64'(PAYLOAD_CAP)) || ($urandom_range(99) < 15);
      npay = (plen > 64'(PAYLOAD_CAP)) ? PAYLOAD_CAP : int'(plen);
      for (int i = 0; i < npay; i++) bytes.push_back(8'($urandom));
    end else begin
      broken = 1'b1;
    end
    if (broken) begin
      cut = $urandom_range(0, bytes.size() - 1);
    end else begin
      ntrail = $urandom_range(0, 3);
      for (int i = 0; i < ntrail; i++) bytes.push_back(8'($urandom));
      cut = bytes.size() - 1;
    end
    for (int i = 0; i <= cut; i++) begin
      add_byte(bytes[i], logic'(i == cut), sidle, ridle, hold && (i == 0));
    end
  endfunction

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (in_valid && in_ready) decode_byte(in_item);
      if (out_valid && out_ready) begin
        if (frame_results.size() == 0) begin
          $error("unexpected result item: kind 0x%0h, data 0x%0h",
                 out_item.kind, out_item.data);
          errors++;
        end else begin
          check_result(frame_results.pop_front(), out_item);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("websocket_frame_decoder verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending.size() != 0 && (!pending[0].hold || frame_results.size() == 0) &&
            $urandom_range(99) >= pending[0].send_idle) begin
          in_item <= pending[0].item;
          in_valid <= 1'b1;
          recv_stall <= pending[0].recv_idle;
          void'(pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    int target;
    foreach (directed[i]) add_byte(directed[i][7:0], directed[i][8], 0, 0, 1'b0);
    for (int p = 0; p < 4; p++) begin
      target = pending.size() + PHASE_ITEMS;
      add_buffer(sidle_of[p], ridle_of[p], 1'b1);
      while (pending.size() < target) add_buffer(sidle_of[p], ridle_of[p], 1'b0);
    end
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || in_valid || frame_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("websocket_frame_decoder verification clean");
    end else begin
      $display("websocket_frame_decoder verification failed");
    end
    $finish;
  end

endmodule

FILE: websocket_frame_decoder.f
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/wsfd_result_fifo.sv
rtl/websocket_frame_decoder.sv
verif/tb.sv
